@@ sv/abse_pkg.sv @@
// abse_pkg: shared types, codes and helpers for the data-processing execute block
// no dependencies; imported by every module of the block except abse_ram
`default_nettype none

package abse_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = 4;
    localparam int FLAGS_W   = 4;

    localparam int FLAG_N_BIT = 3;
    localparam int FLAG_Z_BIT = 2;
    localparam int FLAG_C_BIT = 1;
    localparam int FLAG_V_BIT = 0;

    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD
    } opcode_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_type_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              carry;
    } shift_res_t;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic               write;
        logic               supported;
        logic [FLAGS_W-1:0] flags;
    } alu_res_t;

    function automatic logic [DATA_W-1:0] rotr(input logic [DATA_W-1:0] v,
                                               input logic [4:0] n);
        logic [2*DATA_W-1:0] both;
        both = {v, v} >> n;
        return both[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/abse_if.sv @@
// abse_in_if / abse_out_if: valid-ready channels for instruction and result words
// depends on abse_pkg
`default_nettype none

interface abse_in_if
    import abse_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface abse_out_if
    import abse_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] dest_index;
    logic [DATA_W-1:0]    dest_value;
    logic                 dest_written;
    logic [FLAGS_W-1:0]   flags_now;
    logic                 op_supported;

    modport source (output valid, output dest_index, output dest_value,
                    output dest_written, output flags_now, output op_supported,
                    input ready);
    modport sink   (input valid, input dest_index, input dest_value,
                    input dest_written, input flags_now, input op_supported,
                    output ready);
endinterface

`default_nettype wire

@@ sv/abse_ram.sv @@
// abse_ram: generic single-write, single-read ram with registered read data
// no package dependency
`default_nettype none

module abse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/abse_shifter.sv @@
// abse_shifter: operand 2 barrel shifter with carry-out
// depends on abse_pkg
`default_nettype none

module abse_shifter
    import abse_pkg::*;
(
    input  wire logic [DATA_W-1:0] instr,
    input  wire logic [DATA_W-1:0] rm_val,
    input  wire logic [7:0]        rs_low,
    input  wire logic              cin,
    output shift_res_t             res
);

    logic [4:0]        imm_rot;
    logic [DATA_W-1:0] imm_val;
    logic [7:0]        amt;
    logic              amt_over;
    logic              amt_is_32;
    logic [4:0]        idx_dn;
    logic [4:0]        idx_up;
    shift_type_t       stype;

    always_comb
    begin
        imm_rot   = {instr[11:8], 1'b0};
        imm_val   = rotr(DATA_W'(instr[7:0]), imm_rot);
        amt       = instr[4] ? rs_low : {3'b000, instr[11:7]};
        amt_over  = (amt[7:5] != 3'b000);
        amt_is_32 = (amt == 8'd32);
        idx_dn    = amt[4:0] - 5'd1;
        idx_up    = 5'd0 - amt[4:0];
        stype     = shift_type_t'(instr[6:5]);
        res.value = rm_val;
        res.carry = cin;

        if (instr[25])
        begin
            res.value = imm_val;
            res.carry = (imm_rot == 5'd0) ? cin : imm_val[DATA_W-1];
        end
        else if (amt == 8'd0)
        begin
            // zero immediate amount encodes lsr/asr #32 and rrx
            if (!instr[4])
            begin
                unique case (stype)
                    SH_LSL:
                    begin
                        res.value = rm_val;
                        res.carry = cin;
                    end
                    SH_LSR:
                    begin
                        res.value = '0;
                        res.carry = rm_val[DATA_W-1];
                    end
                    SH_ASR:
                    begin
                        res.value = {DATA_W{rm_val[DATA_W-1]}};
                        res.carry = rm_val[DATA_W-1];
                    end
                    SH_ROR:
                    begin
                        res.value = {cin, rm_val[DATA_W-1:1]};
                        res.carry = rm_val[0];
                    end
                endcase
            end
        end
        else
        begin
            unique case (stype)
                SH_LSL:
                begin
                    if (!amt_over)
                    begin
                        res.value = rm_val << amt[4:0];
                        res.carry = rm_val[idx_up];
                    end
                    else
                    begin
                        res.value = '0;
                        res.carry = amt_is_32 & rm_val[0];
                    end
                end
                SH_LSR:
                begin
                    if (!amt_over)
                    begin
                        res.value = rm_val >> amt[4:0];
                        res.carry = rm_val[idx_dn];
                    end
                    else
                    begin
                        res.value = '0;
                        res.carry = amt_is_32 & rm_val[DATA_W-1];
                    end
                end
                SH_ASR:
                begin
                    if (!amt_over)
                    begin
                        res.value = DATA_W'($signed(rm_val) >>> amt[4:0]);
                        res.carry = rm_val[idx_dn];
                    end
                    else
                    begin
                        res.value = {DATA_W{rm_val[DATA_W-1]}};
                        res.carry = rm_val[DATA_W-1];
                    end
                end
                SH_ROR:
                begin
                    if (amt[4:0] == 5'd0)
                    begin
                        res.value = rm_val;
                        res.carry = rm_val[DATA_W-1];
                    end
                    else
                    begin
                        res.value = rotr(rm_val, amt[4:0]);
                        res.carry = rm_val[idx_dn];
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/abse_alu.sv @@
// abse_alu: data-processing operations and nzc flag update, with v passed through unchanged
// depends on abse_pkg
`default_nettype none

module abse_alu
    import abse_pkg::*;
(
    input  wire logic [3:0]         opcode,
    input  wire logic               s_bit,
    input  wire logic [DATA_W-1:0]  a,
    input  wire shift_res_t         op2,
    input  wire logic [FLAGS_W-1:0] flags,
    output alu_res_t                res
);

    logic [DATA_W:0] sum;
    logic [DATA_W:0] diff_ab;
    logic [DATA_W:0] diff_ba;
    logic            c;
    opcode_t         op;

    always_comb
    begin
        sum           = {1'b0, a} + {1'b0, op2.value};
        diff_ab       = {1'b0, a} - {1'b0, op2.value};
        diff_ba       = {1'b0, op2.value} - {1'b0, a};
        op            = opcode_t'(opcode);
        c             = op2.carry;
        res.value     = '0;
        res.write     = 1'b1;
        res.supported = 1'b1;

        unique case (op)
            OP_AND: res.value = a & op2.value;
            OP_EOR: res.value = a ^ op2.value;
            OP_SUB:
            begin
                res.value = diff_ab[DATA_W-1:0];
                c         = ~diff_ab[DATA_W];
            end
            OP_RSB:
            begin
                res.value = diff_ba[DATA_W-1:0];
                c         = ~diff_ba[DATA_W];
            end
            OP_ADD:
            begin
                res.value = sum[DATA_W-1:0];
                c         = sum[DATA_W];
            end
            OP_TST:
            begin
                res.value = a & op2.value;
                res.write = 1'b0;
            end
            OP_TEQ:
            begin
                res.value = a ^ op2.value;
                res.write = 1'b0;
            end
            OP_CMP:
            begin
                res.value = diff_ab[DATA_W-1:0];
                c         = ~diff_ab[DATA_W];
                res.write = 1'b0;
            end
            OP_ORR: res.value = a | op2.value;
            OP_MOV: res.value = op2.value;
            default:
            begin
                res.value     = '0;
                res.write     = 1'b0;
                res.supported = 1'b0;
            end
        endcase

        res.flags = flags;
        if (res.supported && s_bit)
        begin
            res.flags[FLAG_N_BIT] = res.value[DATA_W-1];
            res.flags[FLAG_Z_BIT] = (res.value == '0);
            res.flags[FLAG_C_BIT] = c;
            res.flags[FLAG_V_BIT] = flags[FLAG_V_BIT];
        end
    end

endmodule

`default_nettype wire

@@ sv/alu_barrel_shift_execute.sv @@
// alu_barrel_shift_execute: top level of the data-processing execute block
// depends on abse_pkg, abse_if, abse_ram, abse_shifter, abse_alu
//
// Executes one data-processing instruction word per clock while results are taken. At
// acceptance the Rn, Rm and Rs operands are read from three copies of a 16 x 32 register file
// ram with a registered read port; the shifter and alu then run, and when the input stage
// advances the register file, flags and result register are written. A write made on the
// same edge as an operand read is forwarded, and entries never written since reset read as
// zero through per-entry valid bits, so no clearing pass is needed. The input side stays
// ready while the result register is full and being taken.
`default_nettype none

module alu_barrel_shift_execute
    import abse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    abse_in_if.sink         instr_ch,
    abse_out_if.source      result_ch
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [DATA_W-1:0]    s1_instr_reg;
    logic                 byp_valid_reg;
    logic [REG_IDX_W-1:0] byp_idx_reg;
    logic [DATA_W-1:0]    byp_value_reg;
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [FLAGS_W-1:0]   flags_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [REG_IDX_W-1:0] out_idx_reg;
    logic [DATA_W-1:0]    out_value_reg;
    logic                 out_written_reg;
    logic [FLAGS_W-1:0]   out_flags_reg;
    logic                 out_supported_reg;

    logic                 accept;
    logic                 s1_adv;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] rd_idx;
    logic [REG_IDX_W-1:0] rn_idx;
    logic [REG_IDX_W-1:0] rm_idx;
    logic [REG_IDX_W-1:0] rs_idx;
    logic [DATA_W-1:0]    rn_q;
    logic [DATA_W-1:0]    rm_q;
    logic [DATA_W-1:0]    rs_q;
    logic [DATA_W-1:0]    rn_val;
    logic [DATA_W-1:0]    rm_val;
    logic [DATA_W-1:0]    rs_val;
    shift_res_t           op2;
    alu_res_t             alu;

    function automatic logic [DATA_W-1:0] resolve(input logic [REG_IDX_W-1:0] idx,
                                                  input logic [DATA_W-1:0]    q,
                                                  input logic                 bv,
                                                  input logic [REG_IDX_W-1:0] bi,
                                                  input logic [DATA_W-1:0]    bval,
                                                  input logic [REG_COUNT-1:0] vbits);
        logic [DATA_W-1:0] r;
        if (bv && (bi == idx))
        begin
            r = bval;
        end
        else if (vbits[idx])
        begin
            r = q;
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    assign s1_adv          = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign instr_ch.ready  = !s1_valid_reg || s1_adv;
    assign accept          = instr_ch.valid && instr_ch.ready;
    assign wr_en           = s1_adv && alu.write;
    assign rd_idx          = s1_instr_reg[15:12];
    assign rn_idx          = s1_instr_reg[19:16];
    assign rm_idx          = s1_instr_reg[3:0];
    assign rs_idx          = s1_instr_reg[11:8];

    // one ram copy per read operand, all written alike
    abse_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_rn (
        .clk   (clk),
        .we    (wr_en),
        .waddr (rd_idx),
        .wdata (alu.value),
        .re    (accept),
        .raddr (instr_ch.instruction[19:16]),
        .rdata (rn_q)
    );

    abse_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_rm (
        .clk   (clk),
        .we    (wr_en),
        .waddr (rd_idx),
        .wdata (alu.value),
        .re    (accept),
        .raddr (instr_ch.instruction[3:0]),
        .rdata (rm_q)
    );

    abse_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_rs (
        .clk   (clk),
        .we    (wr_en),
        .waddr (rd_idx),
        .wdata (alu.value),
        .re    (accept),
        .raddr (instr_ch.instruction[11:8]),
        .rdata (rs_q)
    );

    always_comb
    begin
        rn_val = resolve(rn_idx, rn_q, byp_valid_reg, byp_idx_reg, byp_value_reg, rf_valid_reg);
        rm_val = resolve(rm_idx, rm_q, byp_valid_reg, byp_idx_reg, byp_value_reg, rf_valid_reg);
        rs_val = resolve(rs_idx, rs_q, byp_valid_reg, byp_idx_reg, byp_value_reg, rf_valid_reg);
    end

    abse_shifter u_shifter (
        .instr  (s1_instr_reg),
        .rm_val (rm_val),
        .rs_low (rs_val[7:0]),
        .cin    (flags_reg[FLAG_C_BIT]),
        .res    (op2)
    );

    abse_alu u_alu (
        .opcode (s1_instr_reg[24:21]),
        .s_bit  (s1_instr_reg[20]),
        .a      (rn_val),
        .op2    (op2),
        .flags  (flags_reg),
        .res    (alu)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                byp_valid_reg <= wr_en;
            end
            if (wr_en)
            begin
                rf_valid_reg[rd_idx] <= 1'b1;
            end
            if (s1_adv)
            begin
                flags_reg <= alu.flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg  <= instr_ch.instruction;
            byp_idx_reg   <= rd_idx;
            byp_value_reg <= alu.value;
        end
        if (s1_adv)
        begin
            out_idx_reg       <= rd_idx;
            out_value_reg     <= alu.value;
            out_written_reg   <= alu.write;
            out_flags_reg     <= alu.flags;
            out_supported_reg <= alu.supported;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.dest_index   = out_idx_reg;
    assign result_ch.dest_value   = out_value_reg;
    assign result_ch.dest_written = out_written_reg;
    assign result_ch.flags_now    = out_flags_reg;
    assign result_ch.op_supported = out_supported_reg;

    // a full input stage only takes a new word when its current one moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> s1_adv)
        else $error("word accepted over a held instruction");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg && (out_flags_reg == flags_reg))
        else $error("result register out of step with flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !alu.supported |-> !wr_en && (alu.flags == flags_reg))
        else $error("unsupported opcode changed state");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $stable(flags_reg[FLAG_V_BIT]))
        else $error("overflow flag changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> rf_valid_reg[$past(rd_idx)])
        else $error("register file entry not marked after write");

endmodule

`default_nettype wire
